### hdl/hsase_pkg.sv
// shared types, register indexes and hall sector tables for the hall sector estimator
// no dependencies; imported by the config block and the core

package hsase_pkg;

	// register indexes on the config port (byte address / 4)
	localparam logic [2:0] REG_SECTOR1 = 3'd0;
	localparam logic [2:0] REG_SECTOR2 = 3'd1;
	localparam logic [2:0] REG_SECTOR3 = 3'd2;
	localparam logic [2:0] REG_SECTOR4 = 3'd3;
	localparam logic [2:0] REG_SECTOR5 = 3'd4;
	localparam logic [2:0] REG_SECTOR6 = 3'd5;
	localparam logic [2:0] REG_POS_OFF = 3'd6;
	localparam logic [2:0] REG_NEG_OFF = 3'd7;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int REG_W      = 16;

	// config image seen by the core; base[i] belongs to hall code i+1
	typedef struct packed {
		logic [5:0][REG_W-1:0] base;
		logic [REG_W-1:0]      pos_off;
		logic [REG_W-1:0]      neg_off;
	} cfg_t;

	// forward order 6,4,5,1,3,2
	function automatic logic [2:0] fwd_next(input logic [2:0] c);
		logic [2:0] r;
		case (c)
			3'd1: r = 3'd3;
			3'd2: r = 3'd6;
			3'd3: r = 3'd2;
			3'd4: r = 3'd5;
			3'd5: r = 3'd1;
			3'd6: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] fwd_prev(input logic [2:0] c);
		logic [2:0] r;
		case (c)
			3'd1: r = 3'd5;
			3'd2: r = 3'd3;
			3'd3: r = 3'd1;
			3'd4: r = 3'd6;
			3'd5: r = 3'd4;
			3'd6: r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_legal(input logic [2:0] c);
		return (c != 3'd0) && (c != 3'd7);
	endfunction

	// base angle of a hall code, zero for illegal codes
	function automatic logic [REG_W-1:0] base_of(input cfg_t cfg, input logic [2:0] c);
		logic [REG_W-1:0] r;
		case (c)
			3'd1: r = cfg.base[0];
			3'd2: r = cfg.base[1];
			3'd3: r = cfg.base[2];
			3'd4: r = cfg.base[3];
			3'd5: r = cfg.base[4];
			3'd6: r = cfg.base[5];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hdl/hall_sector_angle_speed_estimator_core.sv
// hall sector angle and speed estimator: an input word is registered in IDLE and decided in
// DECIDE; seeds, repeats, faults and unknown-sector ticks then go to OUT, while a sector step first
// runs the bit-serial divider (one quotient bit per cycle) in DIV; the result word is registered
// in OUT once the output is free; one word at a time, no new word is taken before OUT is left.
// a waiting result sits in the output register while the next word is taken.
// asynchronous active-low reset clears config, estimator state and the handshakes.

module hall_sector_angle_speed_estimator_core
	import hsase_pkg::*;
#(
	parameter int ANGLE_WIDTH = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [2:0] hall_code, rest zero
	input  logic [0:0]            s_tuser,  // [0] command
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// from bit 0: angle_out, speed_out, direction_out, sector_out, fault, fault_count, zero fill
	output logic [8*((2*ANGLE_WIDTH+6+COUNT_WIDTH+7)/8)-1:0] m_tdata,
	// config port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW       = ANGLE_WIDTH;
	localparam int CW       = COUNT_WIDTH;
	localparam int OUT_BITS = 2*AW + 6 + CW;
	localparam int TDATA_W  = 8*((OUT_BITS + 7)/8);

	// one twelfth of a turn
	localparam logic [63:0] TWELFTH64 = (64'd1 << ANGLE_WIDTH) / 64'd12;
	localparam logic [AW-1:0] TWELFTH = TWELFTH64[AW-1:0];
	localparam logic [AW-1:0] SPD_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic [AW-1:0] SPD_MIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	localparam logic [1:0] DIR_FWD = 2'b01;
	localparam logic [1:0] DIR_BWD = 2'b11;

	// sequencer codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	cfg_t cfg;

	logic [1:0]          state_q;
	logic                cmd_q;
	logic [2:0]          code_q;
	logic [2:0]          last_q;
	logic [1:0]          dir_q;
	logic [CW-1:0]       tick_q;
	logic [AW-1:0]       angle_q;
	logic [AW-1:0]       speed_q;
	logic [CW-1:0]       err_q;
	logic                fault_q;
	logic                fwd_q;
	logic [AW-1:0]       edge_q;
	logic                m_tvalid_q;
	logic [OUT_BITS-1:0] out_q;

	logic [AW-1:0] b_code, b_prev, b_next, b_nn;
	logic [AW-1:0] poff, noff;
	logic [AW-1:0] pos_c, neg_c, seed;
	logic [AW-1:0] span;
	logic [CW-1:0] divisor;
	logic [AW-1:0] angle_adv;
	logic          is_fwd, is_bwd;
	logic          div_start, div_done;
	logic [AW-1:0] quot;
	logic [AW-1:0] spd_new;
	logic          out_free;

	hsase_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// sector edges; the offset cancels out of the spans
	assign b_code = AW'(base_of(cfg, code_q));
	assign b_prev = AW'(base_of(cfg, fwd_prev(code_q)));
	assign b_next = AW'(base_of(cfg, fwd_next(code_q)));
	assign b_nn   = AW'(base_of(cfg, fwd_next(fwd_next(code_q))));
	assign poff   = AW'(signed'(cfg.pos_off));
	assign noff   = AW'(signed'(cfg.neg_off));
	assign pos_c  = b_code + poff;
	assign neg_c  = b_next + poff + noff;
	assign seed   = neg_c + TWELFTH;

	assign is_fwd = (code_q == fwd_next(last_q));
	assign is_bwd = (code_q == fwd_prev(last_q)) && is_legal(code_q);

	// backward span is the forward span two sectors ahead
	assign span      = is_fwd ? (b_code - b_prev) : (b_nn - b_next);
	assign divisor   = (tick_q == '0) ? CW'(1) : tick_q;
	assign angle_adv = angle_q + speed_q;

	assign div_start = (state_q == ST_DECIDE) && !cmd_q && is_legal(last_q)
		&& (is_fwd || is_bwd);

	hsase_div #(
		.NW (AW),
		.DW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (span),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// saturate the unsigned quotient into the signed speed range
	always_comb begin
		if (fwd_q) begin
			spd_new = quot[AW-1] ? SPD_MAX : quot;
		end else begin
			spd_new = (quot[AW-1] && (quot[AW-2:0] != '0)) ? SPD_MIN : (~quot + AW'(1));
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= 1'b0;
			code_q     <= '0;
			last_q     <= '0;
			dir_q      <= '0;
			tick_q     <= '0;
			angle_q    <= '0;
			speed_q    <= '0;
			err_q      <= '0;
			fault_q    <= 1'b0;
			fwd_q      <= 1'b0;
			edge_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result word replaces the one taken in the same cycle
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser[0];
						code_q  <= s_tdata[2:0];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					fault_q <= 1'b0;
					state_q <= ST_OUT;
					if (cmd_q) begin
						// seed: angle only, and only for a legal code
						if (is_legal(code_q)) begin
							angle_q <= seed;
						end
					end else if (!is_legal(last_q)) begin
						// no known sector yet: take the code as it is
						last_q  <= code_q;
						angle_q <= angle_adv;
					end else if (is_fwd || is_bwd) begin
						edge_q  <= is_fwd ? pos_c : neg_c;
						fwd_q   <= is_fwd;
						state_q <= ST_DIV;
					end else if (code_q == last_q) begin
						if (tick_q != CNT_MAX) begin
							tick_q <= tick_q + CW'(1);
						end
						angle_q <= angle_adv;
					end else begin
						fault_q <= 1'b1;
						if (err_q != CNT_MAX) begin
							err_q <= err_q + CW'(1);
						end
						angle_q <= angle_adv;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q <= spd_new;
						angle_q <= edge_q + spd_new;
						dir_q   <= fwd_q ? DIR_FWD : DIR_BWD;
						tick_q  <= '0;
						last_q  <= code_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result word, loaded from the updated state
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q <= {err_q, fault_q, last_q, dir_q, speed_q, angle_q};
		end
	end

endmodule

### hdl/hsase_cfg.sv
// config register file on an apb-style port: six sector base angles and two offsets
// depends on hsase_pkg

module hsase_cfg
	import hsase_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx   = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SECTOR1: cfg_q.base[0] <= pwdata[REG_W-1:0];
				REG_SECTOR2: cfg_q.base[1] <= pwdata[REG_W-1:0];
				REG_SECTOR3: cfg_q.base[2] <= pwdata[REG_W-1:0];
				REG_SECTOR4: cfg_q.base[3] <= pwdata[REG_W-1:0];
				REG_SECTOR5: cfg_q.base[4] <= pwdata[REG_W-1:0];
				REG_SECTOR6: cfg_q.base[5] <= pwdata[REG_W-1:0];
				REG_POS_OFF: cfg_q.pos_off <= pwdata[REG_W-1:0];
				REG_NEG_OFF: cfg_q.neg_off <= pwdata[REG_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SECTOR1: prdata = CFG_DATA_W'(cfg_q.base[0]);
			REG_SECTOR2: prdata = CFG_DATA_W'(cfg_q.base[1]);
			REG_SECTOR3: prdata = CFG_DATA_W'(cfg_q.base[2]);
			REG_SECTOR4: prdata = CFG_DATA_W'(cfg_q.base[3]);
			REG_SECTOR5: prdata = CFG_DATA_W'(cfg_q.base[4]);
			REG_SECTOR6: prdata = CFG_DATA_W'(cfg_q.base[5]);
			REG_POS_OFF: prdata = CFG_DATA_W'(cfg_q.pos_off);
			REG_NEG_OFF: prdata = CFG_DATA_W'(cfg_q.neg_off);
			default: prdata = '0;
		endcase
	end

endmodule

### hdl/hsase_div.sv
// bit-serial restoring divider, one quotient bit per cycle shifted into the dividend register
// no package dependencies; used by the core for the speed quotient

module hsase_div #(
	parameter int NW = 16,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    dq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             qbit;

	// shift one dividend bit into the partial remainder and try the subtract
	assign trial = {rem_q, dq_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign qbit  = !diff[DW];

	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[NW-2:0], qbit};
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

endmodule

### hdl/hsase_checker.sv
// port-level checker for the hall sector estimator, bound to the top level
// depends on hall_sector_angle_speed_estimator_core ports

module hsase_checker #(
	parameter int ANGLE_WIDTH = 16,
	parameter int COUNT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [8*((2*ANGLE_WIDTH+6+COUNT_WIDTH+7)/8)-1:0] m_tdata
);

	localparam int DIR_LO   = 2*ANGLE_WIDTH;
	localparam int FAULT_B  = 2*ANGLE_WIDTH + 5;
	localparam int CNT_LO   = 2*ANGLE_WIDTH + 6;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one word at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous word still in work");

	// direction code is forward, backward or unknown
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DIR_LO+1:DIR_LO] != 2'b10)
		else $error("bad direction code");

	// a fault is always counted
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[FAULT_B] |-> m_tdata[CNT_LO+COUNT_WIDTH-1:CNT_LO] != '0)
		else $error("fault with zero fault count");

endmodule

bind hall_sector_angle_speed_estimator_core hsase_checker #(
	.ANGLE_WIDTH (ANGLE_WIDTH),
	.COUNT_WIDTH (COUNT_WIDTH)
) u_hsase_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
